// ----- rtl/psm_pkg.sv -----
package psm_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_PLAY = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam int SAMPLE_W = 16;
  localparam int ID_W     = 8;
  localparam int START_W  = 16;
  localparam int LEN_W    = 17;
  localparam int MASK_W   = 4;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;

  // command broadcast from the controller to every voice cell
  typedef struct packed {
    logic               stop;
    logic [ID_W-1:0]    id;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               loop_en;
  } psm_cmd_t;

  // status a voice cell reports back
  typedef struct packed {
    logic match;
    logic free;
    logic active;
    logic rd_en;
  } psm_stat_t;

endpackage

// ----- rtl/psm_ram.sv -----
module psm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/psm_cell.sv -----
module psm_cell #(
  parameter int ADDR_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  psm_pkg::psm_cmd_t   cmd,
  input  logic                play_we,
  input  logic                tok_in,
  output logic                tok_out,
  output psm_pkg::psm_stat_t  stat,
  output logic [ADDR_W-1:0]   rd_addr
);
  import psm_pkg::*;

  localparam int SUM_W = (ADDR_W > LEN_W + 1) ? ADDR_W : LEN_W + 1;

  logic               active;
  logic [ID_W-1:0]    clip;
  logic [START_W-1:0] start;
  logic [LEN_W-1:0]   length;
  logic [LEN_W-1:0]   cursor;
  logic               loop_en;

  logic             at_end;
  logic [LEN_W-1:0] cur_eff;
  logic [SUM_W-1:0] addr_sum;

  // end of clip: a looping voice restarts, others drop out
  assign at_end  = cursor >= length;
  assign cur_eff = (at_end && loop_en) ? '0 : cursor;

  // read address wraps modulo the memory depth
  assign addr_sum = SUM_W'(start) + SUM_W'(cur_eff);
  assign rd_addr  = addr_sum[ADDR_W-1:0];

  assign stat.match  = active && (clip == cmd.id);
  assign stat.free   = !active;
  assign stat.active = active;
  assign stat.rd_en  = tok_in && active && (!at_end || loop_en);

  // token moves one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else begin
      priority if (play_we) begin
        active <= 1'b1;
      end else if (cmd.stop && stat.match) begin
        active <= 1'b0;
      end else if (tok_in && active && at_end && !loop_en) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (play_we) begin
      clip    <= cmd.id;
      start   <= cmd.start;
      length  <= cmd.length;
      loop_en <= cmd.loop_en;
      cursor  <= '0;
    end else if (stat.rd_en) begin
      cursor  <= cur_eff + LEN_W'(1);
    end
  end

endmodule

// ----- rtl/polyphonic_sample_mixer.sv -----
// Load, play and stop items leave the block idle and produce no result.
// A tick passes a token down the row of voice cells, one cell per cycle, each
// cell using the single sample memory read port in its turn; the sum is
// registered when the token leaves the last cell, then moved to the output in
// HOLD once the output is free, and only then is the next item taken.
// Reset frees all voices and clears out_valid; sample memory and output data are not cleared.
module polyphonic_sample_mixer #(
  parameter int VOICES       = 4,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [15:0]                   address,
  input  logic signed [15:0]            sample_value,
  input  logic [7:0]                    clip_id,
  input  logic [15:0]                   clip_start,
  input  logic [16:0]                   clip_length,
  input  logic                          loop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            mixed_sample,
  output logic [3:0]                    active_voices
);
  import psm_pkg::*;

  // SAMPLE_DEPTH is a power of two; addresses wrap on the low bits
  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int LA_W   = (ADDR_W > 16) ? ADDR_W : 16;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic       in_xfer;
  logic       tok_start;
  logic       tok [VOICES+1];

  psm_cmd_t    cmd;
  psm_stat_t   stat [VOICES];
  logic [ADDR_W-1:0] cell_addr [VOICES];
  logic [VOICES-1:0] play_we;

  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en_any;
  logic              rd_en_d;
  logic [SAMPLE_W-1:0] rd_data;
  logic [LA_W-1:0]   load_addr;

  logic signed [SAMPLE_W-1:0] acc;
  logic signed [SAMPLE_W-1:0] acc_next;
  logic signed [SAMPLE_W:0]   acc_sum;
  logic [MASK_W-1:0]          mask;
  logic signed [SAMPLE_W-1:0] pend_sample;
  logic [MASK_W-1:0]          pend_mask;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // broadcast command
  assign cmd.stop    = in_xfer && (kind == KIND_STOP);
  assign cmd.id      = clip_id;
  assign cmd.start   = clip_start;
  assign cmd.length  = clip_length;
  assign cmd.loop_en = loop;

  // voice pick for play: a voice holding the id wins, else the first free one
  always_comb begin
    logic found_match;
    logic found_free;
    logic [VOICES-1:0] sel_match;
    logic [VOICES-1:0] sel_free;
    found_match = 1'b0;
    found_free  = 1'b0;
    sel_match   = '0;
    sel_free    = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (stat[v].match && !found_match) begin
        sel_match[v] = 1'b1;
        found_match  = 1'b1;
      end
      if (stat[v].free && !found_free) begin
        sel_free[v] = 1'b1;
        found_free  = 1'b1;
      end
    end
    if (in_xfer && (kind == KIND_PLAY) && (clip_length != '0)) begin
      play_we = found_match ? sel_match : sel_free;
    end else begin
      play_we = '0;
    end
  end

  // row of voice cells
  assign tok[0] = tok_start;

  for (genvar v = 0; v < VOICES; v++) begin : g_cell
    psm_cell #(
      .ADDR_W (ADDR_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .play_we (play_we[v]),
      .tok_in  (tok[v]),
      .tok_out (tok[v+1]),
      .stat    (stat[v]),
      .rd_addr (cell_addr[v])
    );
  end

  // only the cell holding the token drives the read port
  always_comb begin
    rd_addr   = '0;
    rd_en_any = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      rd_addr   = rd_addr | (cell_addr[v] & {ADDR_W{stat[v].rd_en}});
      rd_en_any = rd_en_any | stat[v].rd_en;
    end
  end

  assign load_addr = LA_W'(address);

  psm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_xfer && (kind == KIND_LOAD)),
    .waddr (load_addr[ADDR_W-1:0]),
    .wdata (sample_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // running sum, clamped after every voice
  always_comb begin
    acc_sum = {acc[SAMPLE_W-1], acc} + {rd_data[SAMPLE_W-1], rd_data};
    if (!rd_en_d) begin
      acc_next = acc;
    end else if (acc_sum > 17'(signed'(SAT_MAX))) begin
      acc_next = SAT_MAX;
    end else if (acc_sum < 17'(signed'(SAT_MIN))) begin
      acc_next = SAT_MIN;
    end else begin
      acc_next = acc_sum[SAMPLE_W-1:0];
    end
  end

  // voice mask, first four voices only
  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < VOICES) begin : g_on
      assign mask[m] = stat[m].active;
    end else begin : g_off
      assign mask[m] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (kind == KIND_TICK)) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
    if (state == ST_RUN && tok[VOICES]) begin
      pend_sample <= acc_next;
      pend_mask   <= mask;
    end
    if (state == ST_HOLD && (!out_valid || !out_stall)) begin
      mixed_sample  <= pend_sample;
      active_voices <= pend_mask;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tok_start <= 1'b0;
      rd_en_d   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tok_start <= in_xfer && (kind == KIND_TICK);
      rd_en_d   <= rd_en_any;
      // a waiting result in HOLD is replaced below instead
      if (out_valid && !out_stall && (state != ST_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (kind == KIND_TICK)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tok[VOICES]) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/psm_mix_checker.sv -----
// Watches both channels of the mixer, keeps its own copy of the voice state
// and sample memory, and compares every output transfer with the oldest
// predicted mix.
module psm_mix_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [15:0]        address,
  input  logic signed [15:0] sample_value,
  input  logic [7:0]         clip_id,
  input  logic [15:0]        clip_start,
  input  logic [16:0]        clip_length,
  input  logic               loop,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] mixed_sample,
  input  logic [3:0]         active_voices,
  output int                 fail_count,
  output int                 pending
);

  import psm_pkg::*;

  localparam int NUM_VOICES = 4;
  localparam int MEM_WORDS  = 65536;

  typedef struct {
    logic signed [15:0] mix;
    logic [3:0]         voices;
  } mix_result_t;

  // shadow of the block's state
  logic signed [15:0] sample_mem [0:MEM_WORDS-1];
  logic               v_active [NUM_VOICES];
  logic [7:0]         v_clip   [NUM_VOICES];
  logic [15:0]        v_start  [NUM_VOICES];
  logic [16:0]        v_length [NUM_VOICES];
  logic [16:0]        v_cursor [NUM_VOICES];
  logic               v_loop   [NUM_VOICES];

  mix_result_t expected_mix [$];
  int          fail_total;

  always @(posedge clk) begin : track
    mix_result_t want;
    int          hit;
    int          free_v;
    int          chosen;
    int          sum;
    logic [3:0]  mask;
    logic [15:0] rd_addr;
    logic        plays;

    if (rst) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        v_active[v] = 1'b0;
        v_clip[v]   = '0;
        v_start[v]  = '0;
        v_length[v] = '0;
        v_cursor[v] = '0;
        v_loop[v]   = 1'b0;
      end
      expected_mix.delete();
      fail_total = 0;
    end else begin
      // result side: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_mix.size() == 0) begin
          fail_total++;
          $error("unexpected result: mixed_sample %0d active_voices %b",
                 mixed_sample, active_voices);
        end else begin
          want = expected_mix.pop_front();
          if (mixed_sample !== want.mix) begin
            fail_total++;
            $error("mixed_sample: expected %0d, actual %0d", want.mix, mixed_sample);
          end
          if (active_voices !== want.voices) begin
            fail_total++;
            $error("active_voices: expected %b, actual %b", want.voices, active_voices);
          end
        end
      end

      // input side: advance the shadow state on each transfer
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_LOAD: sample_mem[address] = sample_value;

          KIND_PLAY: begin
            // a voice already holding the id wins over the first free one
            hit    = -1;
            free_v = -1;
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (v_active[v] && v_clip[v] == clip_id && hit < 0) hit = v;
              if (!v_active[v] && free_v < 0) free_v = v;
            end
            chosen = (hit >= 0) ? hit : free_v;
            if (clip_length != 0 && chosen >= 0) begin
              v_active[chosen] = 1'b1;
              v_clip[chosen]   = clip_id;
              v_start[chosen]  = clip_start;
              v_length[chosen] = clip_length;
              v_cursor[chosen] = '0;
              v_loop[chosen]   = loop;
            end
          end

          KIND_STOP: begin
            for (int v = 0; v < NUM_VOICES; v++)
              if (v_active[v] && v_clip[v] == clip_id) v_active[v] = 1'b0;
          end

          default: begin
            // tick: voices in order, clamp after every addition
            sum = 0;
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (v_active[v]) begin
                plays = 1'b1;
                if (v_cursor[v] >= v_length[v]) begin
                  if (v_loop[v]) begin
                    v_cursor[v] = '0;
                  end else begin
                    v_active[v] = 1'b0;
                    plays       = 1'b0;
                  end
                end
                if (plays) begin
                  rd_addr = v_start[v] + v_cursor[v][15:0];
                  sum = sum + int'(sample_mem[rd_addr]);
                  if (sum > int'(SAT_MAX)) sum = int'(SAT_MAX);
                  if (sum < int'(SAT_MIN)) sum = int'(SAT_MIN);
                  v_cursor[v] = v_cursor[v] + 17'd1;
                end
              end
            end
            mask = '0;
            for (int v = 0; v < NUM_VOICES && v < 4; v++) mask[v] = v_active[v];
            want.mix    = sum[15:0];
            want.voices = mask;
            expected_mix.push_back(want);
          end
        endcase
      end
    end

    fail_count <= fail_total;
    pending    <= expected_mix.size();
  end

endmodule

// ----- tb/sv/tb_polyphonic_sample_mixer.sv -----
// Stimulus and verdict for the sample mixer; checking lives in psm_mix_checker.
module tb_polyphonic_sample_mixer;

  import psm_pkg::*;

  localparam int RAND_ITEMS  = 1010;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 16;
  // random clips read inside this window, which wraps past the top word
  localparam logic [15:0] WIN_BASE  = 16'hFF00;
  localparam int          WIN_WORDS = 512;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [1:0]         kind         = KIND_LOAD;
  logic [15:0]        address      = '0;
  logic signed [15:0] sample_value = '0;
  logic [7:0]         clip_id      = '0;
  logic [15:0]        clip_start   = '0;
  logic [16:0]        clip_length  = '0;
  logic               loop         = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b1;
  logic signed [15:0] mixed_sample;
  logic [3:0]         active_voices;

  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   hold   = 0;
  // no idling on either side while set
  logic calm   = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  polyphonic_sample_mixer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .address      (address),
    .sample_value (sample_value),
    .clip_id      (clip_id),
    .clip_start   (clip_start),
    .clip_length  (clip_length),
    .loop         (loop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mixed_sample (mixed_sample),
    .active_voices(active_voices)
  );

  psm_mix_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .address      (address),
    .sample_value (sample_value),
    .clip_id      (clip_id),
    .clip_start   (clip_start),
    .clip_length  (clip_length),
    .loop         (loop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mixed_sample (mixed_sample),
    .active_voices(active_voices),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: stall counts only cycles in which a result is offered
  always @(posedge clk) begin : out_pace
    int n;
    if (rst) begin
      n = draw_wait();
      hold      <= n;
      out_stall <= (n != 0);
    end else if (out_valid) begin
      if (!out_stall) n = draw_wait();
      else            n = hold - 1;
      hold      <= n;
      out_stall <= (n != 0);
    end
  end

  // one input transfer, after a random gap
  task automatic send_item(input logic [1:0] k, input logic [15:0] a,
                           input logic signed [15:0] sv, input logic [7:0] id,
                           input logic [15:0] st, input logic [16:0] len,
                           input logic lp);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    address      <= a;
    sample_value <= sv;
    clip_id      <= id;
    clip_start   <= st;
    clip_length  <= len;
    loop         <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // fields an item does not use carry random values
  task automatic load_word(input logic [15:0] a, input logic signed [15:0] sv);
    send_item(KIND_LOAD, a, sv, 8'($urandom), 16'($urandom),
              17'($urandom_range(0, 65536)), 1'($urandom));
  endtask

  task automatic start_clip(input logic [7:0] id, input logic [15:0] st,
                            input logic [16:0] len, input logic lp);
    send_item(KIND_PLAY, 16'($urandom), 16'($urandom), id, st, len, lp);
  endtask

  task automatic stop_clip(input logic [7:0] id);
    send_item(KIND_STOP, 16'($urandom), 16'($urandom), id, 16'($urandom),
              17'($urandom_range(0, 65536)), 1'($urandom));
  endtask

  task automatic tick();
    send_item(KIND_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
              17'($urandom_range(0, 65536)), 1'($urandom));
  endtask

  // mostly a few ids, so retrigger and stop find their voice
  function automatic logic [7:0] pick_id();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
  endfunction

  // mostly short clips so that ends, wraps and frees happen often
  function automatic logic [16:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 17'd0;
    if (r < 65) return 17'($urandom_range(1, 6));
    if (r < 85) return 17'($urandom_range(1, 200));
    return 17'($urandom_range(1, WIN_WORDS));
  endfunction

  // clip start that keeps the whole clip inside the loaded window
  function automatic logic [15:0] pick_start(input logic [16:0] len);
    int span;
    span = (len == '0) ? WIN_WORDS - 1 : WIN_WORDS - int'(len);
    return WIN_BASE + 16'($urandom_range(0, span));
  endfunction

  initial begin
    int r;
    logic [16:0] len;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill the window first so that no clip reads an unwritten word
    for (int a = 0; a < WIN_WORDS; a++) load_word(WIN_BASE + 16'(a), 16'($urandom));
    calm <= 1'b0;

    // directed: extremes, saturation in both directions, address wrap
    load_word(16'hFFFF, SAT_MAX);
    load_word(16'h0000, SAT_MAX);
    load_word(16'h0001, SAT_MAX);
    load_word(16'h0002, SAT_MIN);
    load_word(16'h0100, SAT_MIN);
    load_word(16'h0101, SAT_MIN);
    start_clip(8'd1, 16'h0000, 17'd0, 1'b1);       // zero length: ignored
    start_clip(8'd255, 16'hFFFF, 17'd3, 1'b1);     // wraps past the top word
    start_clip(8'd0, 16'h0000, 17'd65536, 1'b0);   // longest clip
    start_clip(8'd9, 16'h0100, 17'd2, 1'b0);
    start_clip(8'd10, 16'h0100, 17'd1, 1'b1);
    start_clip(8'd11, 16'h0005, 17'd4, 1'b0);      // all voices busy: dropped
    tick();
    tick();
    start_clip(8'd255, 16'h0002, 17'd1, 1'b0);     // retrigger on its own voice
    tick();
    tick();                                        // retriggered one-shot voice freed at end
    stop_clip(8'd200);                             // id not playing
    stop_clip(8'd0);
    tick();
    stop_clip(8'd10);
    tick();
    start_clip(8'd11, 16'hFFFE, 17'd5, 1'b0);
    tick();

    // random traffic
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 300) calm <= 1'b1;
      if (n == 450) calm <= 1'b0;
      if (n == 800) begin
        // hold off until every outstanding mix has come back
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 18) begin
        if ($urandom_range(0, 3) != 0)
          load_word(WIN_BASE + 16'($urandom_range(0, WIN_WORDS - 1)), 16'($urandom));
        else
          load_word(16'($urandom), 16'($urandom));
      end else if (r < 45) begin
        len = pick_len();
        start_clip(pick_id(), pick_start(len), len, 1'($urandom));
      end else if (r < 57) begin
        stop_clip(pick_id());
      end else begin
        tick();
      end
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- polyphonic_sample_mixer.f -----
rtl/psm_pkg.sv
rtl/psm_ram.sv
rtl/psm_cell.sv
rtl/polyphonic_sample_mixer.sv
tb/sv/psm_mix_checker.sv
tb/sv/tb_polyphonic_sample_mixer.sv
